### rtl/core/lpd_pkg.sv
// Shared types and constants for the length-prefix deframer.
package lpd_pkg;

    localparam int LPD_QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_LOW  = 3'b001,
        PH_HIGH = 3'b010,
        PH_BODY = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       first_of_packet;
        logic       last_of_packet;
        logic       length_error;
    } res_t;

    // One command holds the results caused by one input byte: one or two.
    typedef struct packed {
        logic two;
        res_t res0;
        res_t res1;
    } cmd_t;

endpackage

### rtl/core/lpd_front.sv
// Front end: accepts stream bytes, tracks framing and issues result commands.
module lpd_front
    import lpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        chunk_start,
    input  logic [15:0] chunk_length,
    output logic        cmd_wr,
    output cmd_t        cmd
);

    logic        awaiting_reg, awaiting_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  held_reg, held_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] hdr;
    logic [15:0] hdr_rem;
    logic        emit;
    res_t        r0;
    res_t        r1;
    logic        two;

    assign hdr     = {data_byte, held_reg};
    assign hdr_rem = hdr - 16'd2;

    always_comb
    begin
        awaiting_next = awaiting_reg;
        phase_next    = phase_reg;
        held_next     = held_reg;
        left_next     = left_reg;
        emit          = 1'b0;
        two           = 1'b0;
        r0            = '0;
        r1            = '0;
        if (awaiting_reg)
        begin
            if (chunk_start)
            begin
                if (chunk_length > 16'd1)
                begin
                    held_next  = data_byte;
                    phase_next = PH_HIGH;
                end
                else
                begin
                    phase_next = PH_LOW;
                end
            end
            else if (phase_reg != PH_HIGH)
            begin
                phase_next = PH_LOW;
            end
            else if (hdr != chunk_length || hdr < 16'd2)
            begin
                phase_next = PH_LOW;
            end
            else
            begin
                // Header matches its chunk: the stream is now in step.
                awaiting_next      = 1'b0;
                emit               = 1'b1;
                two                = 1'b1;
                r0.packet_byte     = held_reg;
                r0.first_of_packet = 1'b1;
                r1.packet_byte     = data_byte;
                r1.last_of_packet  = (hdr == 16'd2);
                left_next          = hdr_rem;
                phase_next         = (hdr_rem != 16'd0) ? PH_BODY : PH_LOW;
            end
        end
        else
        begin
            case (phase_reg)
                PH_HIGH:
                begin
                    emit = 1'b1;
                    if (hdr < 16'd2)
                    begin
                        r0.length_error = 1'b1;
                        awaiting_next   = 1'b1;
                        phase_next      = PH_LOW;
                        left_next       = '0;
                    end
                    else
                    begin
                        two                = 1'b1;
                        r0.packet_byte     = held_reg;
                        r0.first_of_packet = 1'b1;
                        r1.packet_byte     = data_byte;
                        r1.last_of_packet  = (hdr == 16'd2);
                        left_next          = hdr_rem;
                        phase_next         = (hdr_rem != 16'd0) ? PH_BODY : PH_LOW;
                    end
                end
                PH_BODY:
                begin
                    emit              = 1'b1;
                    r0.packet_byte    = data_byte;
                    r0.last_of_packet = (left_reg <= 16'd1);
                    if (left_reg <= 16'd1)
                    begin
                        left_next  = '0;
                        phase_next = PH_LOW;
                    end
                    else
                    begin
                        left_next = left_reg - 16'd1;
                    end
                end
                default:
                begin
                    held_next  = data_byte;
                    phase_next = PH_HIGH;
                end
            endcase
        end
    end

    assign cmd_wr   = accept && emit;
    assign cmd.two  = two;
    assign cmd.res0 = r0;
    assign cmd.res1 = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b1;
            phase_reg    <= PH_LOW;
            held_reg     <= '0;
            left_reg     <= '0;
        end
        else if (accept)
        begin
            awaiting_reg <= awaiting_next;
            phase_reg    <= phase_next;
            held_reg     <= held_next;
            left_reg     <= left_next;
        end
    end

    // An error command never carries a second result.
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_wr && cmd.res0.length_error |-> !cmd.two)
        else $error("length error command carries two results");

    // Leaving the wait for a clean start always emits the two header bytes.
    a_sync_emits: assert property (@(posedge clk) disable iff (!rst_n)
        accept && awaiting_reg && !awaiting_next |-> cmd_wr && cmd.two)
        else $error("sync without header results");

endmodule

### rtl/core/lpd_cmd_queue.sv
// Short command queue between the front end and the result stage.
module lpd_cmd_queue
    import lpd_pkg::*;
#(
    parameter int DEPTH = LPD_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  cmd_t wr_cmd,
    output logic full,
    input  logic rd,
    output cmd_t rd_cmd,
    output logic not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_cmd    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !wr)
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !not_empty |-> !rd)
        else $error("command queue read while empty");

endmodule

### rtl/core/lpd_back.sv
// Result stage: unpacks commands into single results behind an output register.
module lpd_back
    import lpd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_avail,
    input  cmd_t cmd,
    output logic cmd_rd,
    input  logic pop,
    output logic out_valid,
    output res_t out_res
);

    logic out_valid_reg, out_valid_next;
    res_t out_res_reg, out_res_next;
    logic pend_valid_reg, pend_valid_next;
    res_t pend_res_reg, pend_res_next;
    logic slot_free;

    assign slot_free = !out_valid_reg || pop;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        pend_valid_next = pend_valid_reg;
        pend_res_next   = pend_res_reg;
        cmd_rd          = 1'b0;
        if (slot_free)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_res_next    = pend_res_reg;
                pend_valid_next = 1'b0;
            end
            else if (cmd_avail)
            begin
                cmd_rd          = 1'b1;
                out_valid_next  = 1'b1;
                out_res_next    = cmd.res0;
                pend_valid_next = cmd.two;
                pend_res_next   = cmd.res1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        pend_res_reg <= pend_res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("second result held without a first one on the output");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.length_error |->
            out_res_reg.packet_byte == 8'd0 && !out_res_reg.first_of_packet &&
            !out_res_reg.last_of_packet)
        else $error("error result carries packet fields");

endmodule

### rtl/core/length_prefix_deframer_top.sv
// Top level of the length-prefix deframer.
//
// The block takes one received stream byte per clock (push while full is low)
// and splits the stream into packets whose first two bytes are a little-endian
// 16-bit total length that counts the header itself. Every packet byte comes out
// one at a time on the result queue interface (empty low, pop to take it) with
// first_of_packet on the first header byte and last_of_packet on the final byte.
// After reset, and after any header below two, whole receive chunks are dropped
// until a chunk's own header equals its chunk_length; a header below two in step
// yields one result with length_error set and the other fields zero. An input
// byte is accepted in every cycle in which the command queue between the parser
// and the result stage has room (QUEUE_DEPTH entries); the result stage
// delivers one result per cycle while pop is held high, and since a packet never
// produces more results than it has bytes, full only rises when pop is held low.
// A result reaches the outputs through the command queue, into which its command
// is written, and then the output register of the result stage. A matched header
// is held until its second byte arrives; both header bytes then leave as one
// command, and the result stage gives out the second before any later result.
module length_prefix_deframer_top
    import lpd_pkg::*;
#(
    parameter int QUEUE_DEPTH = LPD_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        chunk_start,
    input  logic [15:0] chunk_length,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  packet_byte,
    output logic        first_of_packet,
    output logic        last_of_packet,
    output logic        length_error
);

    logic accept;
    logic cmd_wr;
    cmd_t cmd_in;
    cmd_t cmd_out;
    logic cmd_rd;
    logic cmd_avail;
    logic out_valid;
    res_t out_res;

    // A request is taken whenever the command queue has room.
    assign accept = push && !full;

    lpd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (data_byte),
        .chunk_start  (chunk_start),
        .chunk_length (chunk_length),
        .cmd_wr       (cmd_wr),
        .cmd          (cmd_in)
    );

    lpd_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (cmd_wr),
        .wr_cmd    (cmd_in),
        .full      (full),
        .rd        (cmd_rd),
        .rd_cmd    (cmd_out),
        .not_empty (cmd_avail)
    );

    lpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_avail (cmd_avail),
        .cmd       (cmd_out),
        .cmd_rd    (cmd_rd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    // The output register holds the oldest result until it is popped.
    assign empty           = !out_valid;
    assign packet_byte     = out_res.packet_byte;
    assign first_of_packet = out_res.first_of_packet;
    assign last_of_packet  = out_res.last_of_packet;
    assign length_error    = out_res.length_error;

endmodule
